/* rtl/multi_voice_sample_mixer_core_assert.svh */
// Assertion macros used by the mixer top-level RTL file.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef MULTI_VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MVSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mixer assertion failed");
`define MVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mixer assertion failed");
`else
`define MVSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MVSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mvsm_pkg.sv */
// Package for the multi-voice sample mixer: widths, codes and shared types.
// Depends on nothing.
package mvsm_pkg;

	localparam int NUM_VOICES_DEF       = 30;
	localparam int SAMPLE_ADDR_BITS_DEF = 16;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W    = 17;
	localparam int TIB_W    = 16;

	localparam logic [TIB_W-1:0] BLOCK_LENGTH_RST = 16'd512;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_QUEUE = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctrl_t;

endpackage

/* rtl/mvsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/mvsm_mix_acc.sv */
// Shared saturating add unit and mix accumulator.
// Depends on mvsm_pkg.
module mvsm_mix_acc
	import mvsm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  acc_ctrl_t                  ctrl,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic signed [SAMPLE_W-1:0] acc
);

	logic signed [SAMPLE_W-1:0] acc_q;
	logic signed [SAMPLE_W:0]   sum;
	logic signed [SAMPLE_W-1:0] sat;

	always_comb begin
		sum = $signed({acc_q[SAMPLE_W-1], acc_q}) + $signed({sample[SAMPLE_W-1], sample});
		if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
			sat = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= sat;
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/multi_voice_sample_mixer_core.sv */
// Top level of the multi-voice sample mixer: sequencer, slot state and memories.
// Depends on mvsm_pkg, mvsm_ram, mvsm_mix_acc and the assertion macro header.
//
// Channel   Handshake             Payload
// request   start / busy          kind, address, sample_value, length
// result    done (one cycle)      status, mix_sample, slot_used, block_end
// config    cfg_we                cfg_wdata (block_length)
//
// A load writes the sample RAM in S_LOAD and then gives done; a queue scans the slots from 0 for a free one.
// A tick reads one slot per cycle through the slot RAM read port, then drains v_s1 and v_s2 before done.
// Reset clears the active bits and the block position; memories are not cleared.
// busy stays high until the result is given; results cannot be stalled.
`include "multi_voice_sample_mixer_core_assert.svh"
module multi_voice_sample_mixer_core
	import mvsm_pkg::*;
#(
	parameter int NUM_VOICES       = NUM_VOICES_DEF,
	parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [15:0]                address,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	input  logic [LEN_W-1:0]           length,
	input  logic                       cfg_we,
	input  logic [TIB_W-1:0]           cfg_wdata,
	output logic                       done,
	output logic [1:0]                 status,
	output logic signed [SAMPLE_W-1:0] mix_sample,
	output logic [5:0]                 slot_used,
	output logic                       block_end
);

	localparam int IdxW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SlotW = SAMPLE_ADDR_BITS + LEN_W;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_VOICES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_QUEUE,
		S_TICK
	} state_t;

	state_t                      state_q;
	logic [SAMPLE_ADDR_BITS-1:0] addr_q;
	logic [SAMPLE_W-1:0]         value_q;
	logic [LEN_W-1:0]            length_q;
	logic [IdxW-1:0]             idx_q;
	logic                        issue_q;
	logic                        v_s1;
	logic [IdxW-1:0]             idx_s1;
	logic                        v_s2;
	logic                        end_q;
	logic [NUM_VOICES-1:0]       active_q;
	logic [TIB_W-1:0]            tib_q;
	logic [TIB_W-1:0]            blen_q;
	logic                        done_q;
	logic [1:0]                  status_q;
	logic signed [SAMPLE_W-1:0]  mix_q;
	logic [5:0]                  slot_q;
	logic                        bend_q;

	logic                        accept;
	logic [TIB_W:0]              blen_eff;
	logic [TIB_W:0]              tib_next;
	logic [SlotW-1:0]            slot_rdata;
	logic [SAMPLE_ADDR_BITS-1:0] s1_addr;
	logic [LEN_W-1:0]            s1_rem;
	logic                        act_s1;
	logic                        use_s1;
	logic [LEN_W-1:0]            rem_after;
	logic                        slot_we;
	logic [IdxW-1:0]             slot_waddr;
	logic [SlotW-1:0]            slot_wdata;
	logic [SAMPLE_W-1:0]         smp_rdata;
	logic signed [SAMPLE_W-1:0]  acc;
	acc_ctrl_t                   acc_ctrl;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign blen_eff = (blen_q == '0) ? (TIB_W+1)'(1) : {1'b0, blen_q};
	assign tib_next = {1'b0, tib_q} + (TIB_W+1)'(1);

	assign s1_addr   = slot_rdata[SlotW-1:LEN_W];
	assign s1_rem    = slot_rdata[LEN_W-1:0];
	assign act_s1    = active_q[idx_s1];
	assign use_s1    = v_s1 && act_s1 && (s1_rem != '0);
	assign rem_after = use_s1 ? (s1_rem - LEN_W'(1)) : s1_rem;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = {addr_q, length_q};
		if (use_s1) begin
			slot_we    = 1'b1;
			slot_waddr = idx_s1;
			slot_wdata = {s1_addr + SAMPLE_ADDR_BITS'(1), rem_after};
		end else if (state_q == S_QUEUE && !active_q[idx_q]) begin
			slot_we = 1'b1;
		end
	end

	assign acc_ctrl.clear = accept && (kind == KIND_TICK);
	assign acc_ctrl.add   = v_s2;

	mvsm_ram #(
		.WIDTH(SlotW),
		.DEPTH(NUM_VOICES)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(idx_q),
		.rdata(slot_rdata)
	);

	mvsm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(1 << SAMPLE_ADDR_BITS)
	) u_sample_ram (
		.clk  (clk),
		.we   (state_q == S_LOAD),
		.waddr(addr_q),
		.wdata(value_q),
		.raddr(s1_addr),
		.rdata(smp_rdata)
	);

	mvsm_mix_acc u_mix_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (acc_ctrl),
		.sample($signed(smp_rdata)),
		.acc   (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q <= BLOCK_LENGTH_RST;
		end else if (cfg_we) begin
			blen_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			addr_q   <= '0;
			value_q  <= '0;
			length_q <= '0;
			idx_q    <= '0;
			issue_q  <= 1'b0;
			v_s1     <= 1'b0;
			idx_s1   <= '0;
			v_s2     <= 1'b0;
			end_q    <= 1'b0;
			active_q <= '0;
			tib_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_OK;
			mix_q    <= '0;
			slot_q   <= '0;
			bend_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						addr_q   <= SAMPLE_ADDR_BITS'(address);
						value_q  <= sample_value;
						length_q <= length;
						idx_q    <= '0;
						unique case (kind)
							KIND_LOAD: begin
								state_q <= S_LOAD;
							end
							KIND_QUEUE: begin
								if (length == '0) begin
									done_q   <= 1'b1;
									status_q <= STAT_ZERO_LEN;
									mix_q    <= '0;
									slot_q   <= '0;
									bend_q   <= 1'b0;
								end else begin
									state_q <= S_QUEUE;
								end
							end
							KIND_TICK: begin
								state_q <= S_TICK;
								issue_q <= 1'b1;
								if (tib_next >= blen_eff) begin
									end_q <= 1'b1;
									tib_q <= '0;
								end else begin
									end_q <= 1'b0;
									tib_q <= tib_next[TIB_W-1:0];
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= STAT_OK;
								mix_q    <= '0;
								slot_q   <= '0;
								bend_q   <= 1'b0;
							end
						endcase
					end
				end
				S_LOAD: begin
					done_q   <= 1'b1;
					status_q <= STAT_OK;
					mix_q    <= '0;
					slot_q   <= '0;
					bend_q   <= 1'b0;
					state_q  <= S_IDLE;
				end
				S_QUEUE: begin
					if (!active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						done_q          <= 1'b1;
						status_q        <= STAT_OK;
						mix_q           <= '0;
						slot_q          <= 6'(idx_q);
						bend_q          <= 1'b0;
						state_q         <= S_IDLE;
					end else if (idx_q == LastIdx) begin
						done_q   <= 1'b1;
						status_q <= STAT_FULL;
						mix_q    <= '0;
						slot_q   <= '0;
						bend_q   <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				S_TICK: begin
					if (issue_q) begin
						idx_q <= idx_q + IdxW'(1);
						if (idx_q == LastIdx) begin
							issue_q <= 1'b0;
						end
					end
					v_s1   <= issue_q;
					idx_s1 <= idx_q;
					v_s2   <= use_s1;
					if (v_s1 && end_q && act_s1 && rem_after == '0) begin
						active_q[idx_s1] <= 1'b0;
					end
					if (!issue_q && !v_s1 && !v_s2) begin
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						mix_q    <= acc;
						slot_q   <= '0;
						bend_q   <= end_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign mix_sample = mix_q;
	assign slot_used  = slot_q;
	assign block_end  = bend_q;

	`MVSM_ASSERT_IMP(a_err_fields_zero, clk, arst_n, done_q && status_q != STAT_OK, mix_q == '0 && !bend_q)
	`MVSM_ASSERT_IMP(a_s2_in_tick, clk, arst_n, v_s2, state_q == S_TICK)
	`MVSM_ASSERT_NXT(a_tick_busy, clk, arst_n, accept && kind == KIND_TICK, busy)
	`MVSM_ASSERT_IMP(a_block_restart, clk, arst_n, done_q && bend_q, tib_q == '0)

endmodule
